@@ hw/rtl/wmhp_pkg.sv @@
// ----------------------------------------------------------------------------
// wmhp_pkg
// Shared constants, codes and types of the 802.11 MAC header parser.
// ----------------------------------------------------------------------------
package wmhp_pkg;

    localparam int MAX_FRAME_BYTES = 4096;
    localparam int COUNT_W         = 13;
    localparam int COUNT_MAX       = (1 << COUNT_W) - 1;
    localparam int HDR_BYTES       = 30;
    localparam int HDR_SHORT       = 24;
    localparam int HDR_LONG        = 30;
    localparam int MIN_FRAME_BYTES = 10;
    localparam int ADDR_W          = 48;
    localparam int ADDR_BYTES      = 6;
    localparam int OFFSET_W        = 5;

    localparam logic [1:0] TYPE_MGMT      = 2'b00;
    localparam logic [1:0] TYPE_DATA      = 2'b10;
    localparam logic [3:0] SUBTYPE_DATA   = 4'd0;
    localparam logic [3:0] SUBTYPE_NULL   = 4'd4;
    localparam logic [1:0] DS_BOTH        = 2'b11;

    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_SHORT       = 2'd1,
        ST_UNSUPPORTED = 2'd2,
        ST_OVERSIZE    = 2'd3
    } status_t;

    typedef struct packed {
        logic                          valid;
        logic [COUNT_W-1:0]            pos;
        logic [15:0]                   frame_ctrl;
        logic [15:0]                   dur_id;
        logic [3:0][ADDR_W-1:0]        address;
        logic [15:0]                   seq_ctrl;
    } view_t;

endpackage

@@ hw/rtl/wmhp_if.sv @@
// ----------------------------------------------------------------------------
// wmhp interfaces
// Byte stream channel and header result channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface wmhp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] frame_byte;
    logic       last_byte;

    modport source (output valid, frame_byte, last_byte, input ready);
    modport sink   (input valid, frame_byte, last_byte, output ready);
endinterface

interface wmhp_result_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [15:0] frame_ctrl;
    logic [15:0] dur_id;
    logic [47:0] address_one;
    logic [47:0] address_two;
    logic [47:0] address_three;
    logic [47:0] address_four;
    logic [15:0] seq_ctrl;
    logic [4:0]  payload_offset;
    logic [12:0] payload_length;

    modport source (output valid, status, frame_ctrl, dur_id, address_one,
                    address_two, address_three, address_four, seq_ctrl,
                    payload_offset, payload_length, input ready);
    modport sink   (input valid, status, frame_ctrl, dur_id, address_one,
                    address_two, address_three, address_four, seq_ctrl,
                    payload_offset, payload_length, output ready);
endinterface

@@ hw/rtl/wlan_mac_header_parser.sv @@
// ----------------------------------------------------------------------------
// wlan_mac_header_parser
// 802.11 MAC header parser: byte stream in, one header result per frame out.
// ----------------------------------------------------------------------------
//  channel  dir  handshake     payload
//  frame    in   valid/ready   frame_byte[7:0], last_byte
//  header   out  valid/ready   status, header words, addresses, payload offset/length
//
//  One byte per cycle while no stall holds the input; a byte passes an input
//  register, then the capture and classification logic, and the last byte of a
//  frame goes from the input register into the result register.
//  Reset clears the valid flags and the byte counter.
//  A waiting result stalls the last byte of the next frame in the input register,
//  and the input with it; earlier bytes of that frame keep flowing.
// ----------------------------------------------------------------------------
module wlan_mac_header_parser (
    input  logic            clk,
    input  logic            rst_n,
    wmhp_byte_if.sink       frame,
    wmhp_result_if.source   header
);

    wmhp_pkg::view_t hdr_view;
    logic            hold;

    wmhp_capture u_capture (
        .clk   (clk),
        .rst_n (rst_n),
        .frame (frame),
        .hold  (hold),
        .view  (hdr_view)
    );

    wmhp_result u_result (
        .clk    (clk),
        .rst_n  (rst_n),
        .view   (hdr_view),
        .hold   (hold),
        .header (header)
    );

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        hdr_view.valid |-> !hold)
        else $error("result overwritten while stalled");

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        hdr_view.valid |=> header.valid)
        else $error("result not presented after last byte");

    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (header.valid && header.status != wmhp_pkg::ST_OK) |->
        (header.payload_offset == '0 && header.payload_length == '0))
        else $error("error result carries nonzero lengths");

    a_offset_legal: assert property (@(posedge clk) disable iff (!rst_n)
        (header.valid && header.status == wmhp_pkg::ST_OK) |->
        (header.payload_offset == 5'(wmhp_pkg::HDR_SHORT) ||
         header.payload_offset == 5'(wmhp_pkg::HDR_LONG)))
        else $error("illegal payload offset");

endmodule

@@ hw/rtl/wmhp_capture.sv @@
// ----------------------------------------------------------------------------
// wmhp_capture
// Input register, byte counter and header byte capture.
// ----------------------------------------------------------------------------
module wmhp_capture (
    input  logic                 clk,
    input  logic                 rst_n,
    wmhp_byte_if.sink            frame,
    input  logic                 hold,
    output wmhp_pkg::view_t      view
);

    logic                             s1_valid_reg;
    logic                             s1_valid_next;
    logic [7:0]                       s1_byte_reg;
    logic                             s1_last_reg;
    logic [wmhp_pkg::COUNT_W-1:0]     count_reg;
    logic [wmhp_pkg::COUNT_W-1:0]     count_next;
    logic [7:0]                       hdr_reg   [wmhp_pkg::HDR_BYTES];
    logic [7:0]                       hdr_merge [wmhp_pkg::HDR_BYTES];
    logic                             accept;
    logic                             s1_go;
    logic                             sat;

    assign sat         = (count_reg == wmhp_pkg::COUNT_W'(wmhp_pkg::COUNT_MAX));
    assign s1_go       = s1_valid_reg && !(s1_last_reg && hold);
    assign frame.ready = !s1_valid_reg || s1_go;
    assign accept      = frame.valid && frame.ready;

    always_comb
    begin
        for (int i = 0; i < wmhp_pkg::HDR_BYTES; i++)
        begin
            if (!sat && count_reg == wmhp_pkg::COUNT_W'(i))
            begin
                hdr_merge[i] = s1_byte_reg;
            end
            else
            begin
                hdr_merge[i] = hdr_reg[i];
            end
        end
    end

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_go)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (s1_go)
        begin
            if (s1_last_reg)
            begin
                count_next = '0;
            end
            else if (!sat)
            begin
                count_next = count_reg + wmhp_pkg::COUNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            count_reg    <= '0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            count_reg    <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_byte_reg <= frame.frame_byte;
            s1_last_reg <= frame.last_byte;
        end
        if (s1_go)
        begin
            for (int i = 0; i < wmhp_pkg::HDR_BYTES; i++)
            begin
                hdr_reg[i] <= hdr_merge[i];
            end
        end
    end

    always_comb
    begin
        view.valid      = s1_go && s1_last_reg;
        view.pos        = count_reg;
        view.frame_ctrl = {hdr_merge[1], hdr_merge[0]};
        view.dur_id     = {hdr_merge[3], hdr_merge[2]};
        view.seq_ctrl   = {hdr_merge[23], hdr_merge[22]};
        for (int k = 0; k < wmhp_pkg::ADDR_BYTES; k++)
        begin
            view.address[0][8*k +: 8] = hdr_merge[4 + k];
            view.address[1][8*k +: 8] = hdr_merge[10 + k];
            view.address[2][8*k +: 8] = hdr_merge[16 + k];
            view.address[3][8*k +: 8] = hdr_merge[24 + k];
        end
    end

endmodule

@@ hw/rtl/wmhp_result.sv @@
// ----------------------------------------------------------------------------
// wmhp_result
// Frame classification, status and result register.
// ----------------------------------------------------------------------------
module wmhp_result (
    input  logic                 clk,
    input  logic                 rst_n,
    input  wmhp_pkg::view_t      view,
    output logic                 hold,
    wmhp_result_if.source        header
);

    logic                              valid_reg;
    logic                              valid_next;
    wmhp_pkg::status_t                 status_next;
    wmhp_pkg::status_t                 status_reg;
    logic [1:0]                        ftype;
    logic [3:0]                        subtype;
    logic                              four;
    logic [wmhp_pkg::OFFSET_W-1:0]     hdr_len;
    logic                              short_hdr;
    logic                              ok;
    logic [15:0]                       fc_reg;
    logic [15:0]                       dur_reg;
    logic [15:0]                       seq_reg;
    logic [wmhp_pkg::ADDR_W-1:0]       addr_reg [4];
    logic [wmhp_pkg::OFFSET_W-1:0]     offset_reg;
    logic [wmhp_pkg::COUNT_W-1:0]      length_reg;

    assign ftype   = view.frame_ctrl[3:2];
    assign subtype = view.frame_ctrl[7:4];
    assign four    = (view.frame_ctrl[9:8] == wmhp_pkg::DS_BOTH);

    always_comb
    begin
        if (ftype == wmhp_pkg::TYPE_DATA && four)
        begin
            hdr_len = wmhp_pkg::OFFSET_W'(wmhp_pkg::HDR_LONG);
        end
        else
        begin
            hdr_len = wmhp_pkg::OFFSET_W'(wmhp_pkg::HDR_SHORT);
        end
    end

    assign short_hdr = (view.pos < (wmhp_pkg::COUNT_W'(hdr_len) - wmhp_pkg::COUNT_W'(1)));

    always_comb
    begin
        if (view.pos >= wmhp_pkg::COUNT_W'(wmhp_pkg::MAX_FRAME_BYTES))
        begin
            status_next = wmhp_pkg::ST_OVERSIZE;
        end
        else if (view.pos < wmhp_pkg::COUNT_W'(wmhp_pkg::MIN_FRAME_BYTES - 1))
        begin
            status_next = wmhp_pkg::ST_SHORT;
        end
        else if (ftype == wmhp_pkg::TYPE_MGMT)
        begin
            status_next = short_hdr ? wmhp_pkg::ST_SHORT : wmhp_pkg::ST_OK;
        end
        else if (ftype == wmhp_pkg::TYPE_DATA)
        begin
            if (subtype != wmhp_pkg::SUBTYPE_DATA && subtype != wmhp_pkg::SUBTYPE_NULL)
            begin
                status_next = wmhp_pkg::ST_UNSUPPORTED;
            end
            else
            begin
                status_next = short_hdr ? wmhp_pkg::ST_SHORT : wmhp_pkg::ST_OK;
            end
        end
        else
        begin
            status_next = wmhp_pkg::ST_UNSUPPORTED;
        end
    end

    assign ok   = (status_next == wmhp_pkg::ST_OK);
    assign hold = valid_reg && !header.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (view.valid)
        begin
            valid_next = 1'b1;
        end
        else if (header.ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (view.valid)
        begin
            status_reg  <= status_next;
            fc_reg      <= ok ? view.frame_ctrl : '0;
            dur_reg     <= ok ? view.dur_id : '0;
            seq_reg     <= ok ? view.seq_ctrl : '0;
            addr_reg[0] <= ok ? view.address[0] : '0;
            addr_reg[1] <= ok ? view.address[1] : '0;
            addr_reg[2] <= ok ? view.address[2] : '0;
            addr_reg[3] <= (ok && ftype == wmhp_pkg::TYPE_DATA && four) ? view.address[3] : '0;
            offset_reg  <= ok ? hdr_len : '0;
            length_reg  <= ok ? (view.pos + wmhp_pkg::COUNT_W'(1) - wmhp_pkg::COUNT_W'(hdr_len))
                              : '0;
        end
    end

    assign header.valid          = valid_reg;
    assign header.status         = status_reg;
    assign header.frame_ctrl     = fc_reg;
    assign header.dur_id         = dur_reg;
    assign header.address_one    = addr_reg[0];
    assign header.address_two    = addr_reg[1];
    assign header.address_three  = addr_reg[2];
    assign header.address_four   = addr_reg[3];
    assign header.seq_ctrl       = seq_reg;
    assign header.payload_offset = offset_reg;
    assign header.payload_length = length_reg;

endmodule

@@ bench/tb_wlan_mac_header_parser.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_wlan_mac_header_parser
// Streams 802.11 frames byte by byte into the header parser. A software model
// of the parser predicts each header result. Every result is checked field
// by field against the oldest prediction. Directed frames cover short,
// management, unsupported, data, four-address and oversize cases. Random
// frames follow. Both channels idle at random.
// ----------------------------------------------------------------------------
module tb_wlan_mac_header_parser;

    localparam int CYCLE_LIMIT  = 500000;
    localparam int RANDOM_BYTES = 1200;
    localparam int RANDOM_FRAMES = 48;
    localparam int IDLE_PCT     = 26;

    typedef struct {
        wmhp_pkg::status_t status;
        logic [15:0] frame_ctrl;
        logic [15:0] dur_id;
        logic [47:0] address_one;
        logic [47:0] address_two;
        logic [47:0] address_three;
        logic [47:0] address_four;
        logic [15:0] seq_ctrl;
        logic [4:0]  payload_offset;
        logic [12:0] payload_length;
    } header_fields_t;

    logic clk = 1'b0;
    logic rst_n;

    wmhp_byte_if   frame ();
    wmhp_result_if header ();

    wlan_mac_header_parser uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .frame  (frame),
        .header (header)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    int unsigned gap_pct   = IDLE_PCT;
    int unsigned stall_pct = IDLE_PCT;
    int unsigned errors    = 0;
    int unsigned cycles    = 0;

    header_fields_t pending_headers[$];

    int unsigned bytes_seen;
    logic [15:0] fc_word;
    logic [15:0] duration_word;
    logic [15:0] sequence_word;
    logic [47:0] address_word[4];

    function automatic void clear_header_state();
        bytes_seen    = 0;
        fc_word       = '0;
        duration_word = '0;
        sequence_word = '0;
        for (int i = 0; i < 4; i++)
        begin
            address_word[i] = '0;
        end
    endfunction

    function automatic void parse_byte(input logic [7:0] b, input logic last);
        int unsigned    len;
        int unsigned    hdr;
        int unsigned    pos;
        logic [1:0]     ftype;
        logic [3:0]     subtype;
        logic           four_addr;
        header_fields_t res;

        hdr = 0;
        if (bytes_seen < wmhp_pkg::COUNT_MAX)
        begin
            pos = bytes_seen;
            if (pos < 2)
                fc_word[8*pos +: 8] = b;
            else if (pos < 4)
                duration_word[8*(pos-2) +: 8] = b;
            else if (pos < 22)
                address_word[(pos-4)/6][8*((pos-4)%6) +: 8] = b;
            else if (pos < 24)
                sequence_word[8*(pos-22) +: 8] = b;
            else if (pos < 30)
                address_word[3][8*(pos-24) +: 8] = b;
            bytes_seen++;
            len = bytes_seen;
        end
        else
        begin
            len = wmhp_pkg::COUNT_MAX + 1;
        end
        if (!last)
            return;

        ftype     = fc_word[3:2];
        subtype   = fc_word[7:4];
        four_addr = (fc_word[9:8] == wmhp_pkg::DS_BOTH);

        if (len > wmhp_pkg::MAX_FRAME_BYTES)
            res.status = wmhp_pkg::ST_OVERSIZE;
        else if (len < wmhp_pkg::MIN_FRAME_BYTES)
            res.status = wmhp_pkg::ST_SHORT;
        else if (ftype == wmhp_pkg::TYPE_MGMT)
        begin
            hdr = wmhp_pkg::HDR_SHORT;
            res.status = (len < hdr) ? wmhp_pkg::ST_SHORT : wmhp_pkg::ST_OK;
        end
        else if (ftype == wmhp_pkg::TYPE_DATA)
        begin
            if (subtype != wmhp_pkg::SUBTYPE_DATA && subtype != wmhp_pkg::SUBTYPE_NULL)
                res.status = wmhp_pkg::ST_UNSUPPORTED;
            else
            begin
                hdr = four_addr ? wmhp_pkg::HDR_LONG : wmhp_pkg::HDR_SHORT;
                res.status = (len < hdr) ? wmhp_pkg::ST_SHORT : wmhp_pkg::ST_OK;
            end
        end
        else
            res.status = wmhp_pkg::ST_UNSUPPORTED;

        res.frame_ctrl     = '0;
        res.dur_id         = '0;
        res.address_one    = '0;
        res.address_two    = '0;
        res.address_three  = '0;
        res.address_four   = '0;
        res.seq_ctrl       = '0;
        res.payload_offset = '0;
        res.payload_length = '0;
        if (res.status == wmhp_pkg::ST_OK)
        begin
            res.frame_ctrl     = fc_word;
            res.dur_id         = duration_word;
            res.address_one    = address_word[0];
            res.address_two    = address_word[1];
            res.address_three  = address_word[2];
            res.address_four   = (ftype == wmhp_pkg::TYPE_DATA && four_addr) ? address_word[3]
                                                                            : '0;
            res.seq_ctrl       = sequence_word;
            res.payload_offset = hdr[4:0];
            res.payload_length = 13'(len - hdr);
        end
        pending_headers.push_back(res);
        clear_header_state();
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && frame.valid && frame.ready)
            parse_byte(frame.frame_byte, frame.last_byte);
    end

    always @(posedge clk)
    begin
        header.ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    function automatic void compare_field(input string name, input logic [47:0] exp_val,
                                          input logic [47:0] act_val);
        if (exp_val !== act_val)
        begin
            errors++;
            $display("%0t %s mismatch: expected %h actual %h", $time, name, exp_val, act_val);
        end
    endfunction

    always @(posedge clk)
    begin
        header_fields_t exp_hdr;
        if (rst_n && header.valid && header.ready)
        begin
            if (pending_headers.size() == 0)
            begin
                errors++;
                $display("%0t unexpected header transaction: expected none actual status %0d",
                         $time, header.status);
            end
            else
            begin
                exp_hdr = pending_headers.pop_front();
                compare_field("status", exp_hdr.status, header.status);
                compare_field("frame_ctrl", exp_hdr.frame_ctrl, header.frame_ctrl);
                compare_field("dur_id", exp_hdr.dur_id, header.dur_id);
                compare_field("address_one", exp_hdr.address_one, header.address_one);
                compare_field("address_two", exp_hdr.address_two, header.address_two);
                compare_field("address_three", exp_hdr.address_three, header.address_three);
                compare_field("address_four", exp_hdr.address_four, header.address_four);
                compare_field("seq_ctrl", exp_hdr.seq_ctrl, header.seq_ctrl);
                compare_field("payload_offset", exp_hdr.payload_offset, header.payload_offset);
                compare_field("payload_length", exp_hdr.payload_length, header.payload_length);
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic last);
        while ($urandom_range(0, 99) < gap_pct)
        begin
            frame.valid <= 1'b0;
            @(posedge clk);
        end
        frame.valid      <= 1'b1;
        frame.frame_byte <= b;
        frame.last_byte  <= last;
        @(posedge clk);
        while (!frame.ready)
            @(posedge clk);
    endtask

    // fill < 0 gives random body bytes
    task automatic send_frame(input logic [15:0] fc, input int len, input int fill);
        logic [7:0] b;
        for (int i = 0; i < len; i++)
        begin
            if (i == 0)
                b = fc[7:0];
            else if (i == 1)
                b = fc[15:8];
            else if (fill < 0)
                b = 8'($urandom);
            else
                b = fill[7:0];
            send_byte(b, i == len - 1);
        end
    endtask

    task automatic test_short_frames();
        send_frame(16'h0000, 1, -1);
        send_frame(16'h00D4, 9, 8'hFF);
        send_frame(16'h0000, 10, -1);
        send_frame(16'h0080, 23, -1);
    endtask

    task automatic test_management_frames();
        send_frame(16'h0000, 24, 8'h00);
        send_frame(16'hFF80, 24, 8'hFF);
        send_frame(16'h0050, 40, -1);
    endtask

    task automatic test_unsupported_types();
        send_frame(16'h00D4, 14, -1);
        send_frame(16'h000C, 24, -1);
        send_frame(16'h0088, 12, -1);
        send_frame(16'h03F8, 30, -1);
    endtask

    task automatic test_data_frames();
        send_frame(16'h0008, 24, -1);
        send_frame(16'h0148, 24, -1);
        send_frame(16'h0208, 36, -1);
    endtask

    task automatic test_four_address_frames();
        send_frame(16'h0308, 30, 8'hFF);
        send_frame(16'h0348, 29, -1);
        send_frame(16'h0308, 24, -1);
        send_frame(16'h0308, 60, -1);
    endtask

    task automatic test_oversize_frames();
        send_frame(16'h0008, wmhp_pkg::MAX_FRAME_BYTES, -1);
        send_frame(16'h0008, wmhp_pkg::MAX_FRAME_BYTES + 1, -1);
        send_frame(16'h00D4, wmhp_pkg::COUNT_MAX + 4, -1);
    endtask

    task automatic test_random_frames();
        int unsigned sent;
        int unsigned frames;
        int unsigned kind;
        int unsigned len;
        int unsigned payload;
        logic [15:0] fc;
        logic [1:0]  ds;

        sent   = 0;
        frames = 0;
        while (sent < RANDOM_BYTES || frames < RANDOM_FRAMES)
        begin
            // hold a stretch with no idling on either side
            if (frames >= 10 && frames < 20)
            begin
                gap_pct   = 0;
                stall_pct = 0;
            end
            else
            begin
                gap_pct   = IDLE_PCT;
                stall_pct = IDLE_PCT;
            end
            payload = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 400)
                                                  : $urandom_range(0, 16);
            kind = $urandom_range(0, 99);
            fc   = 16'($urandom);
            if (kind < 40)
            begin
                fc[3:2] = wmhp_pkg::TYPE_MGMT;
                len     = wmhp_pkg::HDR_SHORT + payload;
            end
            else if (kind < 75)
            begin
                ds      = 2'($urandom);
                fc[3:2] = wmhp_pkg::TYPE_DATA;
                fc[7:4] = $urandom_range(0, 1) ? wmhp_pkg::SUBTYPE_DATA : wmhp_pkg::SUBTYPE_NULL;
                fc[9:8] = ds;
                len     = ((ds == wmhp_pkg::DS_BOTH) ? wmhp_pkg::HDR_LONG : wmhp_pkg::HDR_SHORT)
                          + payload;
            end
            else if (kind < 85)
            begin
                fc[3:2] = $urandom_range(0, 1) ? wmhp_pkg::TYPE_DATA : wmhp_pkg::TYPE_MGMT;
                len     = $urandom_range(1, 29);
            end
            else
            begin
                len = $urandom_range(1, 60);
            end
            send_frame(fc, len, -1);
            sent   += len;
            frames++;
        end
        gap_pct   = IDLE_PCT;
        stall_pct = IDLE_PCT;
    endtask

    initial
    begin
        rst_n            <= 1'b0;
        frame.valid      <= 1'b0;
        frame.frame_byte <= '0;
        frame.last_byte  <= 1'b0;
        clear_header_state();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_short_frames();
        test_management_frames();
        test_unsupported_types();
        test_data_frames();
        test_four_address_frames();
        test_oversize_frames();
        test_random_frames();

        frame.valid <= 1'b0;
        while (pending_headers.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        if (errors == 0 && pending_headers.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

@@ filelist.f @@
hw/rtl/wmhp_pkg.sv
hw/rtl/wmhp_if.sv
hw/rtl/wmhp_capture.sv
hw/rtl/wmhp_result.sv
hw/rtl/wlan_mac_header_parser.sv
bench/tb_wlan_mac_header_parser.sv
